FILE: hdl/ntcf_pkg.sv
// ----------------------------------------------------------------------------
// ntcf_pkg
// Shared constants for the NTC thermistor temperature filter: register map,
// reset values, fixed-point constants and datapath widths.
// ----------------------------------------------------------------------------
package ntcf_pkg;

  // Consecutive invalid readings that raise a fault.
  localparam logic [7:0]  MAX_INVALID  = 8'd4;
  // Nominal thermistor temperature in 1/100 K.
  localparam logic [15:0] NOM_TEMP_CK  = 16'd29815;

  // ln(2) in Q.30 and 273.15 K (0 C) in 1/256 units.
  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [61:0] ZERO_C_256   = 62'd69926;
  localparam logic [61:0] SAT_LIMIT    = 62'd200997;   // 69926 + 131071
  localparam logic [16:0] TEMP_MAX     = 17'd131071;

  // Divider widths.
  localparam int NUM_W = 62;
  localparam int DEN_W = 48;

  // Register indexes.
  localparam logic [2:0] REG_SUPPLY  = 3'd0;
  localparam logic [2:0] REG_BRIDGE  = 3'd1;
  localparam logic [2:0] REG_SERIES  = 3'd2;
  localparam logic [2:0] REG_NOMINAL = 3'd3;
  localparam logic [2:0] REG_BETA    = 3'd4;
  localparam logic [2:0] REG_ALPHA   = 3'd5;
  localparam logic [2:0] REG_OFFSET  = 3'd6;
  localparam logic [2:0] REG_MAXSAFE = 3'd7;

  // Register reset values.
  localparam logic [22:0] RST_SUPPLY  = 23'd3300000;
  localparam logic [22:0] RST_BRIDGE  = 23'd1650000;
  localparam logic [19:0] RST_SERIES  = 20'd10000;
  localparam logic [19:0] RST_NOMINAL = 20'd100000;
  localparam logic [13:0] RST_BETA    = 14'd3950;
  localparam logic [16:0] RST_ALPHA   = 17'd6554;
  localparam logic [15:0] RST_OFFSET  = 16'd0;
  localparam logic [16:0] RST_MAXSAFE = 17'd38400;

endpackage

FILE: hdl/ntcf_div.sv
// ----------------------------------------------------------------------------
// ntcf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntcf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ntcf_pkg::NUM_W-1:0] num,
  input  logic [ntcf_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [ntcf_pkg::NUM_W-1:0] quo
);
  import ntcf_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   qr_r, qr_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [DEN_W:0]     rem2;
  logic [DEN_W:0]     diff;
  logic               ge;

  assign rem2 = {rem_r, qr_r[NUM_W-1]};
  assign diff = rem2 - {1'b0, den_r};
  assign ge   = rem2 >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    qr_nxt   = qr_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      qr_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      qr_nxt  = {qr_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    qr_r  <= qr_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = qr_r;

endmodule

FILE: hdl/ntc_thermistor_temperature_filter_top.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_filter_top
// Thermistor sample to filtered Celsius temperature with invalid-run fault.
// ----------------------------------------------------------------------------
// One ADC sample enters on in_valid/in_stall and yields exactly one result
// on out_valid/out_stall: fault flag, published temperature (1/256 C),
// reading_valid and the consecutive invalid count. Configuration registers
// sit on the APB port at byte addresses 4*i; they are to be written while
// idle by the user, as the block does not enforce it. in_stall is high from
// the accepted transaction until its result is loaded. A valid sample runs
// the whole sequence before out_valid rises, and the next sample is accepted
// only after its result is loaded: the logarithm of each multiplier product
// normalizes one bit per cycle and then runs 24 squaring steps on the shared
// 34x32 multiplier; the Beta division produces 62 quotient bits. An impossible
// voltage or a zero series, nominal or Beta register skips to the result
// directly; a non-positive Beta denominator or a reading at or below 0 C
// leaves the sequence early as well.
// The result sits in an output register; while the receiver stalls, the
// block still accepts the next sample, and only loading the following result
// waits for the register to empty. Reset restores the register defaults and
// clears the filter, the published temperature and the invalid count.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_filter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_adc_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_fault,
  output logic signed [17:0] out_temperature,
  output logic               out_reading_valid,
  output logic [7:0]         out_invalid_run,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ntcf_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MNUM = 5'd1;
  localparam logic [4:0] S_NORM = 5'd2;
  localparam logic [4:0] S_SQ   = 5'd3;
  localparam logic [4:0] S_MDEN = 5'd4;
  localparam logic [4:0] S_MLN  = 5'd5;
  localparam logic [4:0] S_RND  = 5'd6;
  localparam logic [4:0] S_MCL  = 5'd7;
  localparam logic [4:0] S_DEN  = 5'd8;
  localparam logic [4:0] S_DIV  = 5'd9;
  localparam logic [4:0] S_POST = 5'd10;
  localparam logic [4:0] S_FA   = 5'd11;
  localparam logic [4:0] S_FB   = 5'd12;
  localparam logic [4:0] S_FC   = 5'd13;
  localparam logic [4:0] S_PUB  = 5'd14;
  localparam logic [4:0] S_BAD  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  // Configuration registers.
  logic [22:0] supply_r, bridge_r;
  logic [19:0] series_r, nominal_r;
  logic [13:0] beta_r;
  logic [16:0] alpha_r;
  logic [15:0] offset_r;
  logic [16:0] maxsafe_r;
  logic        cfg_wr;

  // Sequencer and datapath registers.
  logic [4:0]         state_r, state_nxt;
  logic [23:0]        vt_r, vt_nxt, vd_r, vd_nxt;
  logic [43:0]        x_r, x_nxt;
  logic [5:0]         e_r, e_nxt;
  logic [30:0]        m_r, m_nxt;
  logic [29:0]        r_r, r_nxt, rn_r, rn_nxt;
  logic [4:0]         iter_r, iter_nxt;
  logic               phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [29:0]        mag_r, mag_nxt, lmag_r, lmag_nxt;
  logic [59:0]        ln_r, ln_nxt;
  logic [45:0]        cl_r, cl_nxt;
  logic [16:0]        tsat_r, tsat_nxt;
  logic [33:0]        at_r, at_nxt;
  logic [49:0]        pf_r, pf_nxt;
  logic [33:0]        filt_r, filt_nxt;
  logic signed [17:0] pub_r, pub_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               rv_r, rv_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_fault_r;
  logic signed [17:0] out_temp_r;
  logic               out_rv_r;
  logic [7:0]         out_run_r;
  logic               load;

  // Shared multiplier.
  logic [33:0] op_a;
  logic [31:0] op_b;
  logic [65:0] prod;

  logic signed [25:0] vt_c;
  logic [23:0]        vs_c;
  logic               in_bad;
  logic [31:0]        mm;
  logic [29:0]        r_sq;
  logic signed [30:0] d_c;
  logic [60:0]        rnd;
  logic [20:0]        b100;
  logic signed [48:0] den_base, den_s;
  logic [16:0]        alpha_c, oma;
  logic [50:0]        fsum;
  logic [34:0]        pr_sum;
  logic signed [19:0] p_c;
  logic               fault_c;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [61:0]        t_c;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r  <= RST_SUPPLY;
      bridge_r  <= RST_BRIDGE;
      series_r  <= RST_SERIES;
      nominal_r <= RST_NOMINAL;
      beta_r    <= RST_BETA;
      alpha_r   <= RST_ALPHA;
      offset_r  <= RST_OFFSET;
      maxsafe_r <= RST_MAXSAFE;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_SUPPLY:  supply_r  <= pwdata[22:0];
        REG_BRIDGE:  bridge_r  <= pwdata[22:0];
        REG_SERIES:  series_r  <= pwdata[19:0];
        REG_NOMINAL: nominal_r <= pwdata[19:0];
        REG_BETA:    beta_r    <= pwdata[13:0];
        REG_ALPHA:   alpha_r   <= pwdata[16:0];
        REG_OFFSET:  offset_r  <= pwdata[15:0];
        REG_MAXSAFE: maxsafe_r <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SUPPLY:  prdata = {9'b0, supply_r};
      REG_BRIDGE:  prdata = {9'b0, bridge_r};
      REG_SERIES:  prdata = {12'b0, series_r};
      REG_NOMINAL: prdata = {12'b0, nominal_r};
      REG_BETA:    prdata = {18'b0, beta_r};
      REG_ALPHA:   prdata = {15'b0, alpha_r};
      REG_OFFSET:  prdata = {16'b0, offset_r};
      REG_MAXSAFE: prdata = {15'b0, maxsafe_r};
      default:     prdata = '0;
    endcase
  end

  // Input voltages in units of 0.5 uV.
  assign vt_c   = 26'(in_adc_code) * 26'sd125 + $signed({2'b00, bridge_r, 1'b0});
  assign vs_c   = {supply_r, 1'b0};
  assign in_bad = (vt_c <= 26'sd0) || (vt_c >= $signed({2'b00, vs_c})) ||
                  (series_r == '0) || (nominal_r == '0) || (beta_r == '0);

  assign alpha_c = (alpha_r > 17'h10000) ? 17'h10000 : alpha_r;
  assign oma     = 17'h10000 - alpha_c;

  always_comb begin
    case (state_r)
      S_MNUM:  begin op_a = {10'b0, vt_r};       op_b = {12'b0, series_r};  end
      S_MDEN:  begin op_a = {10'b0, vd_r};       op_b = {12'b0, nominal_r}; end
      S_SQ:    begin op_a = {3'b0, m_r};         op_b = {1'b0, m_r};        end
      S_MLN:   begin op_a = {4'b0, mag_r};       op_b = {2'b0, LN2_Q30};    end
      S_MCL:   begin op_a = {18'b0, NOM_TEMP_CK}; op_b = {2'b0, lmag_r};    end
      S_DEN:   begin op_a = {18'b0, NOM_TEMP_CK}; op_b = {18'b0, beta_r};   end
      S_FA:    begin op_a = {17'b0, alpha_c};    op_b = {15'b0, tsat_r};    end
      S_FB:    begin op_a = filt_r;              op_b = {15'b0, oma};       end
      default: begin op_a = '0;                  op_b = '0;                 end
    endcase
  end

  assign prod = {32'b0, op_a} * {34'b0, op_b};

  // Squaring step of the logarithm.
  assign mm   = prod[61:30];
  assign r_sq = {r_r[28:0], mm[31]};
  assign d_c  = $signed({1'b0, rn_r}) - $signed({1'b0, r_sq});

  assign rnd  = {1'b0, ln_r} + (61'd1 << 29);

  // Beta equation denominator.
  assign b100     = 21'(beta_r) * 21'd100;
  assign den_base = $signed({4'b0, b100, 24'b0});
  assign den_s    = neg_r ? den_base - $signed({3'b0, cl_r})
                          : den_base + $signed({3'b0, cl_r});
  assign div_start = (state_r == S_DEN) && (den_s > 49'sd0);

  ntcf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({prod[29:0], 32'b0}),
    .den   (den_s[DEN_W-1:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign t_c    = div_quo - ZERO_C_256;
  assign fsum   = {1'b0, at_r, 16'b0} + {1'b0, pf_r} + 51'd32768;
  assign pr_sum = {1'b0, filt_r} + 35'd32768;
  assign p_c    = $signed({1'b0, pr_sum[34:16]}) + 20'(signed'(offset_r));

  assign load    = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign fault_c = (cnt_r >= MAX_INVALID) || (pub_r > $signed({1'b0, maxsafe_r}));

  always_comb begin
    state_nxt = state_r;
    vt_nxt    = vt_r;
    vd_nxt    = vd_r;
    x_nxt     = x_r;
    e_nxt     = e_r;
    m_nxt     = m_r;
    r_nxt     = r_r;
    rn_nxt    = rn_r;
    iter_nxt  = iter_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    lmag_nxt  = lmag_r;
    ln_nxt    = ln_r;
    cl_nxt    = cl_r;
    tsat_nxt  = tsat_r;
    at_nxt    = at_r;
    pf_nxt    = pf_r;
    filt_nxt  = filt_r;
    pub_nxt   = pub_r;
    cnt_nxt   = cnt_r;
    rv_nxt    = rv_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          vt_nxt    = vt_c[23:0];
          vd_nxt    = vs_c - vt_c[23:0];
          phase_nxt = 1'b0;
          state_nxt = in_bad ? S_BAD : S_MNUM;
        end
      end
      S_MNUM, S_MDEN: begin
        x_nxt     = prod[43:0];
        e_nxt     = 6'd43;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        // Shift left until the leading one reaches the top bit.
        if (x_r[43]) begin
          m_nxt     = x_r[43:13];
          r_nxt     = {24'b0, e_r};
          iter_nxt  = '0;
          state_nxt = S_SQ;
        end else begin
          x_nxt = {x_r[42:0], 1'b0};
          e_nxt = e_r - 6'd1;
        end
      end
      S_SQ: begin
        m_nxt    = mm[31] ? mm[31:1] : mm[30:0];
        r_nxt    = r_sq;
        iter_nxt = iter_r + 5'd1;
        if (iter_r == 5'd23) begin
          if (!phase_r) begin
            rn_nxt    = r_sq;
            phase_nxt = 1'b1;
            state_nxt = S_MDEN;
          end else begin
            neg_nxt   = d_c[30];
            mag_nxt   = d_c[30] ? 30'(-d_c) : d_c[29:0];
            state_nxt = S_MLN;
          end
        end
      end
      S_MLN: begin
        ln_nxt    = prod[59:0];
        state_nxt = S_RND;
      end
      S_RND: begin
        lmag_nxt  = rnd[59:30];
        state_nxt = S_MCL;
      end
      S_MCL: begin
        cl_nxt    = prod[45:0];
        state_nxt = S_DEN;
      end
      S_DEN: begin
        state_nxt = div_start ? S_DIV : S_BAD;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (div_quo <= ZERO_C_256) begin
          state_nxt = S_BAD;
        end else begin
          tsat_nxt  = (div_quo >= SAT_LIMIT) ? TEMP_MAX : t_c[16:0];
          state_nxt = S_FA;
        end
      end
      S_FA: begin
        at_nxt    = prod[33:0];
        state_nxt = S_FB;
      end
      S_FB: begin
        pf_nxt    = prod[49:0];
        state_nxt = S_FC;
      end
      S_FC: begin
        filt_nxt  = fsum[49:16];
        state_nxt = S_PUB;
      end
      S_PUB: begin
        if (p_c > 20'sd131071) begin
          pub_nxt = 18'sd131071;
        end else if (p_c < -20'sd131072) begin
          pub_nxt = -18'sd131072;
        end else begin
          pub_nxt = p_c[17:0];
        end
        cnt_nxt   = '0;
        rv_nxt    = 1'b1;
        state_nxt = S_OUT;
      end
      S_BAD: begin
        if (cnt_r < MAX_INVALID) begin
          cnt_nxt = cnt_r + 8'd1;
        end
        rv_nxt    = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      filt_r      <= '0;
      pub_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      filt_r      <= filt_nxt;
      pub_r       <= pub_nxt;
      cnt_r       <= cnt_nxt;
    end
    vt_r    <= vt_nxt;
    vd_r    <= vd_nxt;
    x_r     <= x_nxt;
    e_r     <= e_nxt;
    m_r     <= m_nxt;
    r_r     <= r_nxt;
    rn_r    <= rn_nxt;
    iter_r  <= iter_nxt;
    phase_r <= phase_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    lmag_r  <= lmag_nxt;
    ln_r    <= ln_nxt;
    cl_r    <= cl_nxt;
    tsat_r  <= tsat_nxt;
    at_r    <= at_nxt;
    pf_r    <= pf_nxt;
    rv_r    <= rv_nxt;
    if (load) begin
      out_fault_r <= fault_c;
      out_temp_r  <= pub_r;
      out_rv_r    <= rv_r;
      out_run_r   <= cnt_r;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_fault         = out_fault_r;
  assign out_temperature   = out_temp_r;
  assign out_reading_valid = out_rv_r;
  assign out_invalid_run   = out_run_r;

endmodule
